// ===== hw/rtl/scd_pkg.sv =====
// Shared constants and types for the scaled color to RGBA converter.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package scd_pkg;

    // default fraction width of the Q1.F component fractions
    localparam int FRAC_BITS_DEF = 16;
    // width of a user-range component and of a range register
    localparam int COMP_W = 16;
    // width of one output color byte
    localparam int BYTE_W = 8;
    // configuration register index width and data width
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HSB_MODE     = 3'd0,
        CFG_RANGE_FIRST  = 3'd1,
        CFG_RANGE_SECOND = 3'd2,
        CFG_RANGE_THIRD  = 3'd3,
        CFG_RANGE_ALPHA  = 3'd4
    } t_cfg_idx;

    // reset value of every range register
    localparam logic [COMP_W-1:0] RANGE_RESET = 16'd255;

endpackage

`default_nettype wire

// ===== hw/rtl/scd_in_if.sv =====
// Input channel of the converter: four user-range components and a flag.
// Depends on scd_pkg for the component width.
`default_nettype none

interface scd_in_if;
    logic                       valid;
    logic                       ready;
    logic [scd_pkg::COMP_W-1:0] comp_first;
    logic [scd_pkg::COMP_W-1:0] comp_second;
    logic [scd_pkg::COMP_W-1:0] comp_third;
    logic [scd_pkg::COMP_W-1:0] alpha_in;
    logic                       alpha_full;

    modport source (
        output valid, comp_first, comp_second, comp_third, alpha_in, alpha_full,
        input  ready
    );
    modport sink (
        input  valid, comp_first, comp_second, comp_third, alpha_in, alpha_full,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/scd_out_if.sv =====
// Output channel of the converter: four RGBA bytes.
// Depends on scd_pkg for the byte width.
`default_nettype none

interface scd_out_if;
    logic                       valid;
    logic                       ready;
    logic [scd_pkg::BYTE_W-1:0] red_out;
    logic [scd_pkg::BYTE_W-1:0] green_out;
    logic [scd_pkg::BYTE_W-1:0] blue_out;
    logic [scd_pkg::BYTE_W-1:0] alpha_out;

    modport source (
        output valid, red_out, green_out, blue_out, alpha_out,
        input  ready
    );
    modport sink (
        input  valid, red_out, green_out, blue_out, alpha_out,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/scd_div.sv =====
// Pipelined restoring divider: comp / range as a saturated Q1.F fraction.
// One quotient bit per stage, FRAC_BITS + 1 register stages. Uses scd_pkg.
`default_nettype none

module scd_div #(
    parameter int FRAC_BITS = scd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [scd_pkg::COMP_W-1:0] i_num,
    input  wire logic [scd_pkg::COMP_W-1:0] i_den,
    input  wire logic                       i_force,
    output logic      [FRAC_BITS:0]         o_frac
);
    localparam int W = scd_pkg::COMP_W;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic [W-1:0]         r_rem [0:FRAC_BITS];
    logic [W-1:0]         r_den [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] r_quo [0:FRAC_BITS];
    logic                 r_sat [0:FRAC_BITS];

    logic [W-1:0] den0;
    logic         sat0;

    // replace a zero range by one; a component at or above range saturates
    always_comb begin
        den0 = (i_den == '0) ? W'(1) : i_den;
        sat0 = i_force || (i_num >= den0);
    end

    // load the first stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= sat0 ? '0 : i_num;
            r_den[0] <= den0;
            r_quo[0] <= '0;
            r_sat[0] <= sat0;
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
        logic [W:0] rem2;
        logic       ge;
        always_comb begin
            rem2 = {r_rem[k-1], 1'b0};
            ge   = rem2 >= {1'b0, r_den[k-1]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? W'(rem2 - {1'b0, r_den[k-1]}) : W'(rem2);
                r_den[k] <= r_den[k-1];
                r_quo[k] <= {r_quo[k-1][FRAC_BITS-2:0], ge};
                r_sat[k] <= r_sat[k-1];
            end
        end
    end

    assign o_frac = r_sat[FRAC_BITS] ? ONE : {1'b0, r_quo[FRAC_BITS]};

endmodule

`default_nettype wire

// ===== hw/rtl/scd_hsb.sv =====
// Four-stage color stage: hue sector split, products, blends, HSB or plain bytes.
// Takes the fractions from scd_div; uses scd_pkg for byte width.
`default_nettype none

module scd_hsb #(
    parameter int FRAC_BITS = scd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic                       i_hsb_mode,
    input  wire logic [FRAC_BITS:0]         i_h,
    input  wire logic [FRAC_BITS:0]         i_s,
    input  wire logic [FRAC_BITS:0]         i_v,
    input  wire logic [FRAC_BITS:0]         i_a,
    output logic      [scd_pkg::BYTE_W-1:0] o_red,
    output logic      [scd_pkg::BYTE_W-1:0] o_green,
    output logic      [scd_pkg::BYTE_W-1:0] o_blue,
    output logic      [scd_pkg::BYTE_W-1:0] o_alpha
);
    localparam int F = FRAC_BITS;
    localparam logic [F:0]   ONE = (F+1)'(1) << F;
    localparam logic [F+3:0] TOP = (F+4)'(6) * (F+4)'(ONE) - (F+4)'(1);

    // scale a fraction to a byte, clamped
    function automatic logic [scd_pkg::BYTE_W-1:0] to_byte(input logic [F:0] frac);
        logic [F+8:0] prod;
        logic [F+8:0] b;
        prod = {frac, 8'b0} - (F+9)'(frac);
        b    = prod >> F;
        return (b > (F+9)'(255)) ? 8'hFF : b[7:0];
    endfunction

    // stage 1: hue times six, held below six
    logic [F+3:0] hue6;
    logic [2:0]   r1_sec;
    logic [F-1:0] r1_f;
    logic [F:0]   r1_h, r1_s, r1_v, r1_a;

    always_comb begin
        hue6 = (F+4)'(i_h) * (F+4)'(6);
        if (hue6 > TOP) begin
            hue6 = TOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sec <= hue6[F+2:F];
            r1_f   <= hue6[F-1:0];
            r1_h   <= i_h;
            r1_s   <= i_s;
            r1_v   <= i_v;
            r1_a   <= i_a;
        end
    end

    // stage 2: saturation products
    logic [2*F+1:0] fs_prod, gs_prod;
    logic [F:0]     r2_fs, r2_gs, r2_ps;
    logic [2:0]     r2_sec;
    logic [F:0]     r2_h, r2_s, r2_v, r2_a;

    always_comb begin
        fs_prod = (2*F+2)'(r1_f) * (2*F+2)'(r1_s);
        gs_prod = (2*F+2)'(ONE - (F+1)'(r1_f)) * (2*F+2)'(r1_s);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_fs  <= (F+1)'(fs_prod >> F);
            r2_gs  <= (F+1)'(gs_prod >> F);
            r2_ps  <= ONE - r1_s;
            r2_sec <= r1_sec;
            r2_h   <= r1_h;
            r2_s   <= r1_s;
            r2_v   <= r1_v;
            r2_a   <= r1_a;
        end
    end

    // stage 3: brightness blends
    logic [2*F+1:0] p_prod, q_prod, t_prod;
    logic [F:0]     r3_p, r3_q, r3_t;
    logic [2:0]     r3_sec;
    logic [F:0]     r3_h, r3_s, r3_v, r3_a;

    always_comb begin
        p_prod = (2*F+2)'(r2_v) * (2*F+2)'(r2_ps);
        q_prod = (2*F+2)'(r2_v) * (2*F+2)'(ONE - r2_fs);
        t_prod = (2*F+2)'(r2_v) * (2*F+2)'(ONE - r2_gs);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_p   <= (F+1)'(p_prod >> F);
            r3_q   <= (F+1)'(q_prod >> F);
            r3_t   <= (F+1)'(t_prod >> F);
            r3_sec <= r2_sec;
            r3_h   <= r2_h;
            r3_s   <= r2_s;
            r3_v   <= r2_v;
            r3_a   <= r2_a;
        end
    end

    // stage 4: pick sector outputs (h, s, v outside HSB mode) and scale to bytes
    logic [F:0] sel_r, sel_g, sel_b;

    always_comb begin
        case (r3_sec)
            3'd0: begin sel_r = r3_v; sel_g = r3_t; sel_b = r3_p; end
            3'd1: begin sel_r = r3_q; sel_g = r3_v; sel_b = r3_p; end
            3'd2: begin sel_r = r3_p; sel_g = r3_v; sel_b = r3_t; end
            3'd3: begin sel_r = r3_p; sel_g = r3_q; sel_b = r3_v; end
            3'd4: begin sel_r = r3_t; sel_g = r3_p; sel_b = r3_v; end
            default: begin sel_r = r3_v; sel_g = r3_p; sel_b = r3_q; end
        endcase
        if (!i_hsb_mode) begin
            sel_r = r3_h;
            sel_g = r3_s;
            sel_b = r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_red   <= to_byte(sel_r);
            o_green <= to_byte(sel_g);
            o_blue  <= to_byte(sel_b);
            o_alpha <= to_byte(r3_a);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/scaled_color_to_rgba_top.sv =====
// Scaled color to RGBA converter: top level, config registers, valid pipeline.
// Instantiates scd_div (x4) and scd_hsb; uses scd_pkg, scd_in_if, scd_out_if.
// Output valid follows the valid pipeline r_vld through the divider and scd_hsb stages.
// Throughput: one beat per cycle; the whole pipeline holds while the output stalls.
// Reset (synchronous, active low) clears valid bits and loads the register defaults.
`default_nettype none

module scaled_color_to_rgba_top #(
    parameter int FRAC_BITS = scd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [scd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [scd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    scd_in_if.sink                              i_in,
    scd_out_if.source                           o_out
);
    localparam int LAT = FRAC_BITS + 5;
    localparam int W   = scd_pkg::COMP_W;

    logic         r_hsb_mode;
    logic [W-1:0] r_range_first, r_range_second, r_range_third, r_range_alpha;
    logic [LAT-1:0] r_vld;
    logic           en;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hsb_mode     <= 1'b0;
            r_range_first  <= scd_pkg::RANGE_RESET;
            r_range_second <= scd_pkg::RANGE_RESET;
            r_range_third  <= scd_pkg::RANGE_RESET;
            r_range_alpha  <= scd_pkg::RANGE_RESET;
        end else if (i_cfg_we) begin
            case (scd_pkg::t_cfg_idx'(i_cfg_idx))
                scd_pkg::CFG_HSB_MODE:     r_hsb_mode     <= i_cfg_data[0];
                scd_pkg::CFG_RANGE_FIRST:  r_range_first  <= i_cfg_data;
                scd_pkg::CFG_RANGE_SECOND: r_range_second <= i_cfg_data;
                scd_pkg::CFG_RANGE_THIRD:  r_range_third  <= i_cfg_data;
                scd_pkg::CFG_RANGE_ALPHA:  r_range_alpha  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance when the output stage is empty or being taken
    assign en         = o_out.ready || !r_vld[LAT-1];
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    logic [FRAC_BITS:0] fr_h, fr_s, fr_v, fr_a;

    scd_div #(.FRAC_BITS(FRAC_BITS)) u_div_first (
        .i_clk(i_clk), .i_en(en), .i_num(i_in.comp_first), .i_den(r_range_first),
        .i_force(1'b0), .o_frac(fr_h)
    );
    scd_div #(.FRAC_BITS(FRAC_BITS)) u_div_second (
        .i_clk(i_clk), .i_en(en), .i_num(i_in.comp_second), .i_den(r_range_second),
        .i_force(1'b0), .o_frac(fr_s)
    );
    scd_div #(.FRAC_BITS(FRAC_BITS)) u_div_third (
        .i_clk(i_clk), .i_en(en), .i_num(i_in.comp_third), .i_den(r_range_third),
        .i_force(1'b0), .o_frac(fr_v)
    );
    scd_div #(.FRAC_BITS(FRAC_BITS)) u_div_alpha (
        .i_clk(i_clk), .i_en(en), .i_num(i_in.alpha_in), .i_den(r_range_alpha),
        .i_force(i_in.alpha_full), .o_frac(fr_a)
    );

    scd_hsb #(.FRAC_BITS(FRAC_BITS)) u_hsb (
        .i_clk(i_clk), .i_en(en), .i_hsb_mode(r_hsb_mode),
        .i_h(fr_h), .i_s(fr_s), .i_v(fr_v), .i_a(fr_a),
        .o_red(o_out.red_out), .o_green(o_out.green_out),
        .o_blue(o_out.blue_out), .o_alpha(o_out.alpha_out)
    );

    assign o_out.valid = r_vld[LAT-1];

    // a stalled output must hold the input side
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted while output stalled");

    // an accepted beat enters the first valid stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[0])
        else $error("accepted beat lost at pipeline entry");

    // reset empties the pipeline
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for the scaled color to RGBA converter: random and directed beats,
// a bit-exact color predictor, and a beat-by-beat scoreboard.
// Depends on scd_pkg, scd_in_if, scd_out_if and scaled_color_to_rgba_top.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = scd_pkg::FRAC_BITS_DEF;
    localparam longint unsigned ONE = 64'd1 << FB;
    localparam int LATENCY = FB + 5;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [scd_pkg::COMP_W-1:0] c1;
        logic [scd_pkg::COMP_W-1:0] c2;
        logic [scd_pkg::COMP_W-1:0] c3;
        logic [scd_pkg::COMP_W-1:0] a;
        logic                       full;
    } t_pixel;

    typedef struct packed {
        logic [scd_pkg::BYTE_W-1:0] r;
        logic [scd_pkg::BYTE_W-1:0] g;
        logic [scd_pkg::BYTE_W-1:0] b;
        logic [scd_pkg::BYTE_W-1:0] a;
    } t_rgba;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [scd_pkg::CFG_IDX_W-1:0] i_cfg_idx = scd_pkg::CFG_HSB_MODE;
    logic [scd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    scd_in_if  pix_ch();
    scd_out_if rgba_ch();

    scaled_color_to_rgba_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in(pix_ch.sink), .o_out(rgba_ch.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor copy of the registers
    logic            hsb_q = 1'b0;
    logic [15:0]     range_q [4] = '{16'd255, 16'd255, 16'd255, 16'd255};

    t_pixel pending_pixels [$];
    t_rgba  expected_rgba [$];
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    bit     hold_sender = 1'b0;
    bit     stim_done = 1'b0;
    int     errors = 0;
    int     quiet_cycles = 0;

    function automatic longint unsigned frac_of(logic [15:0] comp, logic [15:0] range);
        longint unsigned den, quo;
        den = (range == 0) ? 1 : range;
        quo = ({48'd0, comp} << FB) / den;
        return (quo > ONE) ? ONE : quo;
    endfunction

    function automatic logic [7:0] byte_of(longint unsigned fr);
        longint unsigned bv;
        bv = (fr * 255) >> FB;
        return (bv > 255) ? 8'd255 : bv[7:0];
    endfunction

    function automatic t_rgba color_of(t_pixel px);
        longint unsigned h, s, v, al, r, g, b, h6, sec, f, p, q, t;
        t_rgba o;
        h = frac_of(px.c1, range_q[0]);
        s = frac_of(px.c2, range_q[1]);
        v = frac_of(px.c3, range_q[2]);
        al = px.full ? ONE : frac_of(px.a, range_q[3]);
        r = h; g = s; b = v;
        if (hsb_q) begin
            h6 = h * 6;
            if (h6 > 6 * ONE - 1) h6 = 6 * ONE - 1;
            sec = h6 >> FB;
            f = h6 & (ONE - 1);
            p = (v * (ONE - s)) >> FB;
            q = (v * (ONE - ((f * s) >> FB))) >> FB;
            t = (v * (ONE - (((ONE - f) * s) >> FB))) >> FB;
            case (sec)
                0: begin r = v; g = t; b = p; end
                1: begin r = q; g = v; b = p; end
                2: begin r = p; g = v; b = t; end
                3: begin r = p; g = q; b = v; end
                4: begin r = t; g = p; b = v; end
                default: begin r = v; g = p; b = q; end
            endcase
        end
        o.r = byte_of(r); o.g = byte_of(g); o.b = byte_of(b); o.a = byte_of(al);
        return o;
    endfunction

    // drive pixel beats from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
        end else begin
            if (pix_ch.valid && pix_ch.ready) begin
                expected_rgba.push_back(color_of({pix_ch.comp_first, pix_ch.comp_second,
                    pix_ch.comp_third, pix_ch.alpha_in, pix_ch.alpha_full}));
            end
            if (!pix_ch.valid || pix_ch.ready) begin
                if (pending_pixels.size() > 0 && !hold_sender
                        && $urandom_range(99) >= send_idle_pct) begin
                    t_pixel px;
                    px = pending_pixels.pop_front();
                    pix_ch.valid <= 1'b1;
                    pix_ch.comp_first <= px.c1;
                    pix_ch.comp_second <= px.c2;
                    pix_ch.comp_third <= px.c3;
                    pix_ch.alpha_in <= px.a;
                    pix_ch.alpha_full <= px.full;
                end else begin
                    pix_ch.valid <= 1'b0;
                end
            end
        end
    end

    // check result beats against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rgba_ch.ready <= 1'b0;
        end else begin
            if (rgba_ch.valid && rgba_ch.ready) begin
                if (expected_rgba.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected beat, actual %h", $time,
                        {rgba_ch.red_out, rgba_ch.green_out, rgba_ch.blue_out,
                         rgba_ch.alpha_out});
                end else begin
                    t_rgba e;
                    e = expected_rgba.pop_front();
                    if (rgba_ch.red_out !== e.r) begin
                        errors++;
                        $display("%0t: red expected %h actual %h", $time, e.r,
                            rgba_ch.red_out);
                    end
                    if (rgba_ch.green_out !== e.g) begin
                        errors++;
                        $display("%0t: green expected %h actual %h", $time, e.g,
                            rgba_ch.green_out);
                    end
                    if (rgba_ch.blue_out !== e.b) begin
                        errors++;
                        $display("%0t: blue expected %h actual %h", $time, e.b,
                            rgba_ch.blue_out);
                    end
                    if (rgba_ch.alpha_out !== e.a) begin
                        errors++;
                        $display("%0t: alpha expected %h actual %h", $time, e.a,
                            rgba_ch.alpha_out);
                    end
                end
            end
            rgba_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // count cycles without any accepted beat while work is outstanding
    always @(posedge i_clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (rgba_ch.valid && rgba_ch.ready)
                || (!pix_ch.valid && pending_pixels.size() == 0
                    && expected_rgba.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        pix_ch.valid = 1'b0;
        pix_ch.comp_first = '0;
        pix_ch.comp_second = '0;
        pix_ch.comp_third = '0;
        pix_ch.alpha_in = '0;
        pix_ch.alpha_full = 1'b0;
        rgba_ch.ready = 1'b0;
    end

    task automatic wait_drained();
        while (pending_pixels.size() > 0 || pix_ch.valid || expected_rgba.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // one write beat, then the predictor copy follows and the task waits with write enable low
    task automatic write_reg(scd_pkg::t_cfg_idx idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            scd_pkg::CFG_HSB_MODE: hsb_q = val[0];
            scd_pkg::CFG_RANGE_FIRST: range_q[0] = val;
            scd_pkg::CFG_RANGE_SECOND: range_q[1] = val;
            scd_pkg::CFG_RANGE_THIRD: range_q[2] = val;
            default: range_q[3] = val;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_comp(logic [15:0] range);
        int k;
        k = $urandom_range(9);
        if (k == 0) return 16'd0;
        if (k == 1) return range;
        if (k == 2) return 16'($urandom);
        return 16'($urandom_range(range));
    endfunction

    task automatic add_random(int n);
        t_pixel px;
        repeat (n) begin
            px.c1 = pick_comp(range_q[0]);
            px.c2 = pick_comp(range_q[1]);
            px.c3 = pick_comp(range_q[2]);
            px.a = pick_comp(range_q[3]);
            px.full = $urandom_range(3) == 0;
            pending_pixels.push_back(px);
        end
    endtask

    function automatic logic [15:0] pick_range();
        int k;
        k = $urandom_range(5);
        if (k == 0) return 16'd1;
        if (k == 1) return 16'hFFFF;
        if (k == 2) return 16'd0;
        if (k == 3) return 16'd255;
        return 16'($urandom_range(65535, 1));
    endfunction

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes at reset ranges, then hsb corners
        send_idle_pct = 23; recv_idle_pct = 81;
        pending_pixels.push_back('{16'd0, 16'd0, 16'd0, 16'd0, 1'b0});
        pending_pixels.push_back('{16'd255, 16'd255, 16'd255, 16'd255, 1'b0});
        pending_pixels.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0});
        pending_pixels.push_back('{16'd128, 16'd300, 16'd1, 16'd7, 1'b1});
        pending_pixels.push_back('{16'hAAAA, 16'h5555, 16'h00FF, 16'hFF00, 1'b1});
        wait_drained();
        write_reg(scd_pkg::CFG_HSB_MODE, 16'd1);
        for (int i = 0; i <= 6; i++)
            pending_pixels.push_back('{16'(i * 255 / 6), 16'd255, 16'd255, 16'd128, 1'b0});
        pending_pixels.push_back('{16'd255, 16'd128, 16'd200, 16'd0, 1'b0});
        pending_pixels.push_back('{16'hFFFF, 16'd255, 16'd255, 16'd255, 1'b1});
        pending_pixels.push_back('{16'd40, 16'd0, 16'd200, 16'd255, 1'b0});
        pending_pixels.push_back('{16'd100, 16'd255, 16'd0, 16'd255, 1'b0});
        wait_drained();
        // zero ranges: zero component gives zero, others saturate
        write_reg(scd_pkg::CFG_RANGE_FIRST, 16'd0);
        write_reg(scd_pkg::CFG_RANGE_SECOND, 16'd0);
        write_reg(scd_pkg::CFG_RANGE_THIRD, 16'd0);
        write_reg(scd_pkg::CFG_RANGE_ALPHA, 16'd0);
        pending_pixels.push_back('{16'd0, 16'd0, 16'd0, 16'd0, 1'b0});
        pending_pixels.push_back('{16'd1, 16'd1, 16'd1, 16'd1, 1'b0});
        pending_pixels.push_back('{16'd0, 16'd1, 16'd1, 16'd0, 1'b0});
        wait_drained();

        // random phases with new settings between them
        for (int ph = 0; ph < 24; ph++) begin
            if (ph == 8) begin send_idle_pct = 81; recv_idle_pct = 23; end
            if (ph == 16) begin send_idle_pct = 0; recv_idle_pct = 0; end
            write_reg(scd_pkg::CFG_HSB_MODE, (ph % 3 != 0) ? 16'd1 : 16'd0);
            write_reg(scd_pkg::CFG_RANGE_FIRST, (ph == 5) ? 16'hFFFF : pick_range());
            write_reg(scd_pkg::CFG_RANGE_SECOND, (ph == 5) ? 16'hFFFF : pick_range());
            write_reg(scd_pkg::CFG_RANGE_THIRD, (ph == 6) ? 16'd1 : pick_range());
            write_reg(scd_pkg::CFG_RANGE_ALPHA, pick_range());
            add_random(80);
            if (ph == 10) begin
                // hold the sender until the pipeline empties
                while (pending_pixels.size() > 40) @(posedge i_clk);
                hold_sender = 1'b1;
                while (pix_ch.valid || expected_rgba.size() > 0) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            wait_drained();
        end
        i_cfg_we <= 1'b0;
        wait_drained();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/scd_pkg.sv
hw/rtl/scd_in_if.sv
hw/rtl/scd_out_if.sv
hw/rtl/scd_div.sv
hw/rtl/scd_hsb.sv
hw/rtl/scaled_color_to_rgba_top.sv
test/testbench.sv
